// File: sv/spkc_pkg.sv
// -----------------------------------------------------------------------------
// spkc_pkg: shared definitions for the server page kind classifier
// Holds the literal table, the group and kind codes, and the chain geometry.
// -----------------------------------------------------------------------------
package spkc_pkg;

   localparam int unsigned LIT_COUNT = 12;
   // The longest literal is 19 bytes, so the chain has one cell per byte position.
   localparam int unsigned CHAIN_LEN = 19;

   typedef logic [LIT_COUNT-1:0]   lit_vec_type;
   typedef logic [8*CHAIN_LEN-1:0] lit_text_type;

   typedef enum logic [1:0] {
      GRP_JSP    = 2'd0,
      GRP_ASPNET = 2'd1,
      GRP_ASP    = 2'd2
   } lit_group_type;

   typedef enum logic [1:0] {
      KIND_GENERIC = 2'd0,
      KIND_JSP     = 2'd1,
      KIND_ASPNET  = 2'd2,
      KIND_ASP     = 2'd3
   } page_kind_type;

   typedef struct packed {
      logic jsp;
      logic aspnet;
      logic asp;
   } group_hits_type;

   // Text is right-aligned: the last character sits in the low byte.
   localparam lit_text_type LIT_TEXT [LIT_COUNT] = '{
      "<jsp:",
      "<%@ taglib",
      "java.lang",
      "java.io",
      "Runtime.getRuntime",
      "runat=\"server\"",
      "<asp:",
      "<%@ Import",
      "System.Web",
      "<%@ Language",
      "Server.CreateObject",
      "<%@ LANGUAGE"
   };

   localparam int unsigned LIT_LEN [LIT_COUNT] = '{
      5, 10, 9, 7, 18, 14, 5, 10, 10, 12, 19, 12
   };

   localparam lit_group_type LIT_GROUP [LIT_COUNT] = '{
      GRP_JSP, GRP_JSP, GRP_JSP, GRP_JSP, GRP_JSP,
      GRP_ASPNET, GRP_ASPNET, GRP_ASPNET, GRP_ASPNET,
      GRP_ASP, GRP_ASP, GRP_ASP
   };

endpackage

// File: sv/spkc_cell.sv
// -----------------------------------------------------------------------------
// spkc_cell: one byte position of the literal match chain
// Holds, per literal, whether its prefix up to this position ended at the
// previous byte, and hands the updated bits to the next cell.
// -----------------------------------------------------------------------------
module spkc_cell #(
   parameter int unsigned Pos = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 clear,
   input  logic [7:0]           data_byte,
   input  spkc_pkg::lit_vec_type prev_state,
   output spkc_pkg::lit_vec_type match,
   output spkc_pkg::lit_vec_type state
);
   import spkc_pkg::*;

   lit_vec_type state_ff;
   lit_vec_type state_in;

   // Compare the byte against each literal's character at this position.
   for (genvar l = 0; l < LIT_COUNT; l++) begin : g_lit
      if (Pos < LIT_LEN[l]) begin : g_used
         assign match[l] = prev_state[l] &&
            (data_byte == LIT_TEXT[l][8*(LIT_LEN[l]-1-Pos) +: 8]);
      end else begin : g_unused
         assign match[l] = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (clear) begin
         state_in = '0;
      end else if (advance) begin
         state_in = match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// File: sv/server_page_kind_classifier_core.sv
// -----------------------------------------------------------------------------
// server_page_kind_classifier_core: classify a sniff window by server page kind
// Streams window bytes through a chain of match cells and reports JSP,
// ASP.NET, classic ASP or generic on the last byte of each window.
// -----------------------------------------------------------------------------
//
//  channel | direction | ports                                  | beat
//  --------+-----------+----------------------------------------+------------------
//  req     | in        | req_valid/ready, data_byte, window_end | one window byte
//  rsp     | out       | rsp_valid/ready, page_kind             | one kind per window
//
// One byte per cycle while rsp is not stalled: each byte is compared in every
// chain cell at once and the cells take the new prefix bits in the same edge,
// so the next byte may follow in the next cycle. A kind appears on rsp in the
// cycle after the window's last byte is accepted.
// Reset clears the chain, the group flags and the output register at once;
// no clearing pass is needed.
// While a kind waits on rsp, req stays ready as long as rsp_ready is high;
// any byte stalls while the waiting kind is not taken.
//
module server_page_kind_classifier_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_window_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_page_kind
);
   import spkc_pkg::*;

   logic accept;
   logic window_close;

   lit_vec_type chain_prev  [CHAIN_LEN];
   lit_vec_type chain_match [CHAIN_LEN];
   lit_vec_type chain_state [CHAIN_LEN];
   lit_vec_type lit_hit;

   group_hits_type grp_hit;
   group_hits_type seen;
   group_hits_type flags_ff;
   group_hits_type flags_in;

   page_kind_type kind;
   page_kind_type rsp_kind_ff;
   page_kind_type rsp_kind_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   // Take a byte whenever the output slot is free or being drained.
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign window_close = accept && req_window_end;

   // Match chain: cell zero always sees an open prefix; the rest chain on.
   for (genvar p = 0; p < CHAIN_LEN; p++) begin : g_cell
      if (p == 0) begin : g_head
         assign chain_prev[p] = '1;
      end else begin : g_body
         assign chain_prev[p] = chain_state[p-1];
      end

      spkc_cell #(
         .Pos (p)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (accept),
         .clear      (window_close),
         .data_byte  (req_data_byte),
         .prev_state (chain_prev[p]),
         .match      (chain_match[p]),
         .state      (chain_state[p])
      );
   end

   // A literal ends at this byte when its last cell matches.
   for (genvar l = 0; l < LIT_COUNT; l++) begin : g_hit
      assign lit_hit[l] = chain_match[LIT_LEN[l]-1][l];
   end

   always_comb begin
      grp_hit = '0;
      for (int l = 0; l < LIT_COUNT; l++) begin
         unique case (LIT_GROUP[l])
            GRP_JSP:    grp_hit.jsp    = grp_hit.jsp    | lit_hit[l];
            GRP_ASPNET: grp_hit.aspnet = grp_hit.aspnet | lit_hit[l];
            GRP_ASP:    grp_hit.asp    = grp_hit.asp    | lit_hit[l];
            default:    grp_hit        = grp_hit;
         endcase
      end
   end

   // Hits on the last byte still count toward its window.
   assign seen = flags_ff | grp_hit;

   always_comb begin
      priority if (seen.jsp) begin
         kind = KIND_JSP;
      end else if (seen.aspnet) begin
         kind = KIND_ASPNET;
      end else if (seen.asp) begin
         kind = KIND_ASP;
      end else begin
         kind = KIND_GENERIC;
      end
   end

   always_comb begin
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         flags_in = seen;
      end
      // Drop the flags and load the verdict at the window's end.
      if (window_close) begin
         flags_in     = '0;
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= KIND_GENERIC;
      end else begin
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_kind_ff  <= rsp_kind_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_page_kind = rsp_kind_ff;

   // A closed window always yields a beat on the next cycle.
   a_close_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      window_close |=> rsp_valid_ff)
      else $error("window end did not produce a result");

   // A byte that does not close a window never creates a result.
   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      (accept && !req_window_end && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid_ff)
      else $error("result appeared without a window end");

   // Flags and chain start clean after a window closes.
   a_flags_cleared : assert property (@(posedge clock) disable iff (reset)
      window_close |=> (flags_ff == '0) && (chain_state[0] == '0))
      else $error("window state not cleared");

   // A JSP hit anywhere in the window wins the verdict.
   a_jsp_priority : assert property (@(posedge clock) disable iff (reset)
      (window_close && seen.jsp) |=> (rsp_kind_ff == KIND_JSP))
      else $error("JSP priority violated");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top: testbench for the server page kind classifier core
// Streams sniff windows byte by byte, predicts the page kind of every window
// from a behavioral matcher over a private copy of the marker list, and checks
// each kind beat on rsp in order. Both sides idle and stall at random.
// -----------------------------------------------------------------------------
module tb_top;
   import spkc_pkg::*;

   localparam int MARKER_COUNT = 12;
   localparam int HISTORY_DEPTH = 18;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BYTES = 950;
   localparam int RANDOM_WINDOWS = 48;

   // DUT connections; every input is known from time zero.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_window_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_page_kind;

   // Marker list, kept here independently of the package table.
   string marker_text [MARKER_COUNT] = '{
      "<jsp:", "<%@ taglib", "java.lang", "java.io", "Runtime.getRuntime",
      "runat=\"server\"", "<asp:", "<%@ Import", "System.Web",
      "<%@ Language", "Server.CreateObject", "<%@ LANGUAGE"
   };
   lit_group_type marker_group [MARKER_COUNT] = '{
      GRP_JSP, GRP_JSP, GRP_JSP, GRP_JSP, GRP_JSP,
      GRP_ASPNET, GRP_ASPNET, GRP_ASPNET, GRP_ASPNET,
      GRP_ASP, GRP_ASP, GRP_ASP
   };

   // Matcher state: previous bytes of the window (newest first) and group flags.
   logic [7:0] recent_bytes [HISTORY_DEPTH];
   logic       jsp_marked;
   logic       aspnet_marked;
   logic       asp_marked;

   page_kind_type expected_kinds [$];
   logic [7:0]    window_text [$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            bytes_sent = 0;
   int            windows_sent = 0;
   logic          steady_flow = 1'b0;

   server_page_kind_classifier_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_window_end (req_window_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_page_kind  (rsp_page_kind)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bail out on a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic clear_window_state();
      foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
      jsp_marked = 1'b0;
      aspnet_marked = 1'b0;
      asp_marked = 1'b0;
   endtask

   // Advance the matcher by one accepted byte; on the window's last byte,
   // queue the kind by priority JSP, ASP.NET, classic ASP, generic.
   task automatic match_window_byte(input logic [7:0] b, input logic last);
      int         n;
      int         lag;
      logic       hit;
      logic [7:0] seen;
      for (int m = 0; m < MARKER_COUNT; m++) begin
         n = marker_text[m].len();
         hit = 1'b1;
         for (int i = 0; i < n; i++) begin
            lag = n - 1 - i;
            seen = (lag == 0) ? b : recent_bytes[lag-1];
            if (seen != marker_text[m][i]) hit = 1'b0;
         end
         if (hit) begin
            case (marker_group[m])
               GRP_JSP:    jsp_marked = 1'b1;
               GRP_ASPNET: aspnet_marked = 1'b1;
               default:    asp_marked = 1'b1;
            endcase
         end
      end
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = b;
      if (last) begin
         if (jsp_marked) expected_kinds.push_back(KIND_JSP);
         else if (aspnet_marked) expected_kinds.push_back(KIND_ASPNET);
         else if (asp_marked) expected_kinds.push_back(KIND_ASP);
         else expected_kinds.push_back(KIND_GENERIC);
         clear_window_state();
      end
   endtask

   // Send one byte beat. Entered at a rising edge; returns at its acceptance edge
   // with valid still high, so a follow-on beat can go out back to back.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_window_end <= last;
      do @(posedge clock); while (!req_ready);
      match_window_byte(b, last);
      bytes_sent++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) window_text.push_back(s[i]);
   endtask

   // Send the buffered window with the end flag on its last byte, then empty it.
   task automatic send_window();
      for (int i = 0; i < window_text.size(); i++)
         send_byte(window_text[i], i == window_text.size() - 1);
      window_text.delete();
      windows_sent++;
   endtask

   // Hold the sender until every queued kind is back, then let the pipe settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_kinds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: stall at random, take each kind beat and compare it.
   initial begin
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!rsp_valid);
         if (expected_kinds.size() == 0) begin
            report_mismatch($sformatf("kind %0d with no window pending", rsp_page_kind));
         end else begin
            if (rsp_page_kind !== expected_kinds[0])
               report_mismatch($sformatf("page_kind got %0d want %0d",
                                         rsp_page_kind, expected_kinds[0]));
            void'(expected_kinds.pop_front());
         end
         stall = steady_flow ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Single-byte windows at both byte extremes; the zero byte matches nothing.
   task automatic test_byte_extremes();
      window_text.push_back(8'h00);
      send_window();
      window_text.push_back(8'hFF);
      send_window();
   endtask

   // A marker ending exactly on the end byte counts; JSP beats ASP.NET.
   task automatic test_group_priority();
      add_text("<asp:");
      send_window();
      add_text("<asp:<jsp:");
      send_window();
   endtask

   // Split a marker across two windows: the cleared history must break it.
   task automatic test_window_boundary();
      add_text("<js");
      send_window();
      add_text("p:");
      send_window();
   endtask

   // The longest marker spans the current byte plus the full history.
   task automatic test_longest_marker();
      add_text("Server.CreateObject");
      send_window();
   endtask

   // Random windows built from whole markers, damaged markers, prefixes and
   // noise bytes; short windows keep ends landing back to back.
   task automatic test_random_windows();
      int  pieces;
      int  pick;
      int  idx;
      int  pos;
      int  drained;
      drained = 0;
      while (bytes_sent < RANDOM_BYTES || windows_sent < RANDOM_WINDOWS) begin
         steady_flow = ($urandom_range(0, 5) == 0);
         pieces = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
         repeat (pieces) begin
            pick = $urandom_range(0, 9);
            idx  = $urandom_range(0, MARKER_COUNT - 1);
            if (pick < 5) begin
               add_text(marker_text[idx]);
            end else if (pick < 7) begin
               // Flip one bit somewhere in the marker: a near miss.
               add_text(marker_text[idx]);
               pos = window_text.size() - 1 - $urandom_range(0, marker_text[idx].len() - 1);
               window_text[pos] = window_text[pos] ^ (8'h01 << $urandom_range(0, 7));
            end else if (pick < 8) begin
               add_text(marker_text[idx].substr(0,
                        $urandom_range(0, marker_text[idx].len() - 2)));
            end else begin
               repeat ($urandom_range(1, 6))
                  window_text.push_back(8'($urandom_range(0, 255)));
            end
         end
         if (window_text.size() == 0 || $urandom_range(0, 3) == 0)
            window_text.push_back(8'($urandom_range(0, 255)));
         send_window();
         // Pause once midway until nothing is outstanding.
         if (drained == 0 && bytes_sent >= RANDOM_BYTES / 2) begin
            drain_results();
            drained = 1;
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      clear_window_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_byte_extremes();
      test_group_priority();
      test_window_boundary();
      test_longest_marker();
      test_random_windows();
      drain_results();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: server_page_kind_classifier_core.f
sv/spkc_pkg.sv
sv/spkc_cell.sv
sv/server_page_kind_classifier_core.sv
bench/tb_top.sv
